// ----- sv/arpc_pkg.sv -----
// shared types and codes for the arp cache table
`default_nettype none
package arpc_pkg;

    localparam int IDX_W  = 6;
    localparam int PORT_W = 8;
    localparam int CNT_W  = 7;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_STATIC  = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_FIND    = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;
    localparam logic [2:0] OP_SWEEP   = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] ip_address;
        logic [47:0] mac_address;
        logic [3:0]  port_id;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] entry_address;
        logic [47:0] found_mac;
        logic [3:0]  found_port;
        logic [31:0] learned_time;
        logic        entry_static;
        logic        last;
    } out_item_t;

    // probe that walks the row of cells, one cell per cycle
    typedef struct packed {
        logic              active;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic              hit_static;
        logic [47:0]       hit_mac;
        logic [PORT_W-1:0] hit_port;
        logic [31:0]       hit_learned;
        logic [31:0]       hit_expiry;
        logic              free_ok;
        logic [IDX_W-1:0]  free_idx;
        logic              min_ok;
        logic [31:0]       min_key;
        logic [IDX_W-1:0]  min_idx;
        logic [CNT_W-1:0]  pend_cnt;
    } token_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic [31:0]       key;
        logic [31:0]       now;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [47:0]       wr_mac;
        logic [PORT_W-1:0] wr_port;
        logic [31:0]       wr_expiry;
        logic              wr_static;
        logic              inval_en;
        logic [IDX_W-1:0]  inval_idx;
        logic              clr_all;
        logic              mark;
    } cmd_t;

endpackage
`default_nettype wire

// ----- sv/arpc_cell.sv -----
// one table slot: binding storage plus one stage of the probe chain
`default_nettype none
module arpc_cell #(
    parameter int CELL_IDX  = 0,
    parameter int PORT_BITS = 4
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire  arpc_pkg::cmd_t    cmd,
    input  wire  arpc_pkg::token_t  tok_in,
    output arpc_pkg::token_t        tok_out
);

    localparam logic [arpc_pkg::IDX_W-1:0] MY_IDX = arpc_pkg::IDX_W'(CELL_IDX);

    logic                  valid_reg;
    logic                  pend_reg;
    logic                  static_reg;
    logic [31:0]           key_reg;
    logic [47:0]           mac_reg;
    logic [PORT_BITS-1:0]  port_reg;
    logic [31:0]           learned_reg;
    logic [31:0]           expiry_reg;
    arpc_pkg::token_t      tok_reg;
    arpc_pkg::token_t      tok_next;

    logic wr_here;
    logic inval_here;

    assign wr_here    = cmd.wr_en && (cmd.wr_idx == MY_IDX);
    assign inval_here = cmd.inval_en && (cmd.inval_idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_all)
                valid_reg <= 1'b0;
            else if (wr_here)
                valid_reg <= 1'b1;
            else if (inval_here)
                valid_reg <= 1'b0;

            if (cmd.clr_all || inval_here)
                pend_reg <= 1'b0;
            else if (cmd.mark)
                pend_reg <= valid_reg && !static_reg && (cmd.now >= expiry_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            static_reg  <= cmd.wr_static;
            key_reg     <= cmd.key;
            mac_reg     <= cmd.wr_mac;
            port_reg    <= cmd.wr_port[PORT_BITS-1:0];
            learned_reg <= cmd.now;
            expiry_reg  <= cmd.wr_expiry;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg && (key_reg == cmd.key) && !tok_in.hit)
        begin
            tok_next.hit         = 1'b1;
            tok_next.hit_idx     = MY_IDX;
            tok_next.hit_static  = static_reg;
            tok_next.hit_mac     = mac_reg;
            tok_next.hit_port    = '0;
            tok_next.hit_port[PORT_BITS-1:0] = port_reg;
            tok_next.hit_learned = learned_reg;
            tok_next.hit_expiry  = expiry_reg;
        end
        if (!valid_reg && !tok_in.free_ok)
        begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = MY_IDX;
        end
        if (pend_reg)
        begin
            tok_next.pend_cnt = tok_in.pend_cnt + arpc_pkg::CNT_W'(1);
            if (!tok_in.min_ok || (key_reg < tok_in.min_key))
            begin
                tok_next.min_ok  = 1'b1;
                tok_next.min_key = key_reg;
                tok_next.min_idx = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ----- sv/arp_cache_table_with_aging.sv -----
// arp cache table with aging: sequencer and the row of slot cells
// Usage:
//   in_valid/in_ready carries one operation beat (insert, insert static,
//   refresh, find, remove, clear, sweep expired); out_valid/out_ready
//   carries result beats, the final one of each operation with last set.
//   cfg_wr_en/cfg_wr_data writes the entry lifetime in ticks; write it
//   only while the block is idle.
// Flow:
//   each operation sends a probe down the row of TABLE_DEPTH cells, one
//   cell per cycle, and out_valid rises once the probe leaves the last
//   cell and the result is registered. A sweep first marks expired
//   slots in the S_MARK state, then runs one probe pass per removed
//   address, each pass starting when the previous result beat is taken,
//   emitting addresses in ascending order.
//   One operation is in flight at a time; in_ready is high only when the
//   previous operation has delivered all its results.
// Reset:
//   every slot becomes empty and the lifetime returns to zero; the block
//   is ready in the first cycle after reset.
// Stall:
//   a result beat holds until taken; the next sweep pass starts only then.
`default_nettype none
module arp_cache_table_with_aging #(
    parameter int TABLE_DEPTH = 32,
    parameter int PORT_BITS   = 4
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  arpc_pkg::in_item_t   in_data,
    output logic                       out_valid,
    input  wire                        out_ready,
    output arpc_pkg::out_item_t        out_data,
    input  wire                        cfg_wr_en,
    input  wire  [31:0]                cfg_wr_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MARK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0]           state_reg, state_next;
    logic                 launch_reg, launch_next;
    logic                 more_reg, more_next;
    logic                 out_valid_reg, out_valid_next;
    arpc_pkg::out_item_t  res_reg, res_next;
    logic [31:0]          life_reg;
    logic [2:0]           op_reg;
    logic [31:0]          key_reg;
    logic [47:0]          mac_reg;
    logic [3:0]           port_reg;
    logic [31:0]          now_reg;
    logic [31:0]          exp_reg;
    logic [32:0]          exp_sum;
    logic                 accept;
    logic                 done;

    arpc_pkg::cmd_t       cmd;
    arpc_pkg::token_t     launch_tok;
    arpc_pkg::token_t     tok [TABLE_DEPTH+1];
    arpc_pkg::token_t     fin;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign fin      = tok[TABLE_DEPTH];
    assign done     = (state_reg == S_SCAN) && fin.active;
    assign exp_sum  = {1'b0, in_data.now_time} + {1'b0, life_reg};

    always_comb
    begin
        launch_tok        = '0;
        launch_tok.active = launch_reg;
    end

    assign tok[0] = launch_tok;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            arpc_cell #(
                .CELL_IDX  (g),
                .PORT_BITS (PORT_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            life_reg <= '0;
        else if (cfg_wr_en)
            life_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_data.operation;
            key_reg  <= in_data.ip_address;
            mac_reg  <= in_data.mac_address;
            port_reg <= in_data.port_id;
            now_reg  <= in_data.now_time;
            if (in_data.operation == arpc_pkg::OP_STATIC)
                exp_reg <= in_data.now_time;
            else
                exp_reg <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        more_next      = more_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;

        cmd            = '0;
        cmd.key        = key_reg;
        cmd.now        = now_reg;
        cmd.wr_mac     = mac_reg;
        cmd.wr_port[3:0] = port_reg;
        cmd.wr_expiry  = exp_reg;
        cmd.wr_static  = (op_reg == arpc_pkg::OP_STATIC);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.operation == arpc_pkg::OP_SWEEP)
                        state_next = S_MARK;
                    else
                    begin
                        state_next  = S_SCAN;
                        launch_next = 1'b1;
                    end
                end
            end
            S_MARK:
            begin
                cmd.mark    = 1'b1;
                state_next  = S_SCAN;
                launch_next = 1'b1;
            end
            S_SCAN:
            begin
                if (done)
                begin
                    res_next       = '0;
                    res_next.last  = 1'b1;
                    more_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                    case (op_reg)
                        arpc_pkg::OP_INSERT, arpc_pkg::OP_STATIC:
                        begin
                            if (fin.hit || fin.free_ok)
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_idx = fin.hit ? fin.hit_idx : fin.free_idx;
                                res_next.status = arpc_pkg::ST_OK;
                            end
                            else
                                res_next.status = arpc_pkg::ST_FULL;
                        end
                        arpc_pkg::OP_REFRESH:
                        begin
                            if (fin.hit)
                            begin
                                cmd.wr_en  = !fin.hit_static;
                                cmd.wr_idx = fin.hit_idx;
                                res_next.status = arpc_pkg::ST_OK;
                            end
                            else
                                res_next.status = arpc_pkg::ST_MISS;
                        end
                        arpc_pkg::OP_FIND:
                        begin
                            if (!fin.hit || (!fin.hit_static && (now_reg >= fin.hit_expiry)))
                                res_next.status = arpc_pkg::ST_MISS;
                            else
                            begin
                                res_next.status        = arpc_pkg::ST_OK;
                                res_next.entry_address = key_reg;
                                res_next.found_mac     = fin.hit_mac;
                                res_next.found_port    = fin.hit_port[3:0];
                                res_next.learned_time  = fin.hit_learned;
                                res_next.entry_static  = fin.hit_static;
                            end
                        end
                        arpc_pkg::OP_REMOVE:
                        begin
                            if (fin.hit)
                            begin
                                cmd.inval_en  = 1'b1;
                                cmd.inval_idx = fin.hit_idx;
                                res_next.status = arpc_pkg::ST_OK;
                            end
                            else
                                res_next.status = arpc_pkg::ST_MISS;
                        end
                        arpc_pkg::OP_CLEAR:
                        begin
                            cmd.clr_all     = 1'b1;
                            res_next.status = arpc_pkg::ST_OK;
                        end
                        arpc_pkg::OP_SWEEP:
                        begin
                            if (fin.min_ok)
                            begin
                                // smallest pending key goes out this pass
                                cmd.inval_en  = 1'b1;
                                cmd.inval_idx = fin.min_idx;
                                res_next.status        = arpc_pkg::ST_OK;
                                res_next.entry_address = fin.min_key;
                                res_next.last  = (fin.pend_cnt == arpc_pkg::CNT_W'(1));
                                more_next      = (fin.pend_cnt != arpc_pkg::CNT_W'(1));
                            end
                            else
                                res_next.status = arpc_pkg::ST_MISS;
                        end
                        default:
                            res_next.status = arpc_pkg::ST_MISS;
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (more_reg)
                    begin
                        state_next  = S_SCAN;
                        launch_next = 1'b1;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

endmodule
`default_nettype wire

// ----- sv/arpc_checker.sv -----
// port-level checks for the arp cache table, bound to the top level
`default_nettype none
module arpc_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       in_valid,
    input wire                       in_ready,
    input wire arpc_pkg::out_item_t  out_data,
    input wire                       out_valid,
    input wire                       out_ready
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one operation at a time: no new beat while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted beat");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == arpc_pkg::ST_OK ||
                       out_data.status == arpc_pkg::ST_MISS ||
                       out_data.status == arpc_pkg::ST_FULL))
        else $error("unknown status code");

endmodule

bind arp_cache_table_with_aging arpc_checker u_arpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
`default_nettype wire
